### src/rrva_pkg.sv
package rrva_pkg;

	// message types (upper nibble of the status byte)
	localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
	localparam logic [3:0] MSG_NOTE_ON  = 4'h9;

	// field widths
	localparam int STATUS_W   = 8;
	localparam int NOTE_W     = 7;
	localparam int VEL_W      = 7;
	localparam int VOICE_W    = 4;
	localparam int CFG_W      = 5;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register map
	localparam logic REG_VOICES_IN_USE = 1'b0;

	// voice slots addressable by the voice index
	localparam int ADDRESSABLE_VOICES = 16;
	localparam int DEF_MAX_VOICES     = 16;
	localparam logic [CFG_W-1:0] VOICES_RESET = 5'd16;

	// command to the voice table
	typedef struct packed {
		logic              set;   // store note, mark held and active
		logic              clr;   // release voice (inactive)
		logic [NOTE_W-1:0] note;  // note to store or to compare
	} tbl_cmd_t;

endpackage

### src/rrva_voice_table.sv
module rrva_voice_table #(
	parameter int SLOTS = 16,
	parameter int IDX_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  idx,
	input  rrva_pkg::tbl_cmd_t cmd,
	output logic              match
);
	import rrva_pkg::*;

	logic [NOTE_W-1:0] note_q [SLOTS];
	logic [SLOTS-1:0]  holds_q;
	logic [SLOTS-1:0]  active_q;

	// shared compare unit: one slot per cycle
	assign match = holds_q[idx] && (note_q[idx] == cmd.note);

	always_ff @(posedge clk) begin
		if (cmd.set) begin
			note_q[idx] <= cmd.note;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holds_q  <= '0;
			active_q <= '0;
		end else begin
			if (cmd.set) begin
				holds_q[idx]  <= 1'b1;
				active_q[idx] <= 1'b1;
			end else if (cmd.clr) begin
				active_q[idx] <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_active_held: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q & ~holds_q) == '0)
		else $error("active voice without a stored note");
	a_set_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set |=> active_q[$past(idx)] && holds_q[$past(idx)])
		else $error("note-on did not activate voice");
	a_set_clr: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.set && cmd.clr))
		else $error("set and release in same cycle");
`endif

endmodule

### src/midi_round_robin_voice_allocator_top.sv
// round-robin voice allocator for midi channel messages
// input stream (s_*): one three-byte midi message per transfer
// output stream (m_*): one routed message per voice, m_tlast on the final
//   transfer caused by an input message; messages other than note-on or
//   note-off cause no output transfer
// apb port: voices_in_use at byte address 0 (5 bits, reset 16)
// note-on (nonzero velocity): goes to the voice at the round-robin pointer,
//   the sequencer moves to its ON state and the result is then registered in
//   the output register; the next message waits for that, plus any output stall
// note-off, or note-on with zero velocity: one shared note comparator steps
//   through all voice slots, one slot per cycle unless the scan halts on a
//   stall, and the input is held off for the whole scan, plus a flush step
//   when at least one voice matches
// other messages: the sequencer stays idle, next message accepted in the following cycle
// s_tready is high only while the sequencer is idle
// a match is kept in a pending register until the next match or the end of
//   the scan shows whether it is the last; when the receiver stalls the scan
//   halts at the next match and resumes once the output register frees up
// reset clears the pointer, the note-held and active flags, the sequencer and
//   the output valid; no clearing pass is needed
module midi_round_robin_voice_allocator_top #(
	parameter int MAX_VOICES = rrva_pkg::DEF_MAX_VOICES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// status_byte [7:0], note_number [14:8], velocity [21:15], zero [23:22]
	input  logic [rrva_pkg::IN_DATA_W-1:0]  s_tdata,
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// voice_index [3:0], out_status [11:4], out_note [18:12],
	// out_velocity [25:19], voice_gate [26], zero [31:27]
	output logic [rrva_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast,   // last_result
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rrva_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rrva_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rrva_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import rrva_pkg::*;

	// voice slots in use by hardware, capped at what voice_index can address
	localparam int SLOTS = (MAX_VOICES > ADDRESSABLE_VOICES) ? ADDRESSABLE_VOICES :
		((MAX_VOICES < 1) ? 1 : MAX_VOICES);
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [CFG_W-1:0] SLOTS_C = CFG_W'(SLOTS);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ON    = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]          state_q;
	logic [CFG_W-1:0]    voices_q;
	logic [IDX_W-1:0]    next_voice_q;
	logic [IDX_W-1:0]    scan_q;
	logic                pend_vld_q;
	logic [IDX_W-1:0]    pend_idx_q;
	logic [STATUS_W-1:0] msg_status_q;
	logic [NOTE_W-1:0]   msg_note_q;
	logic [VEL_W-1:0]    msg_vel_q;

	logic                m_tvalid_q;
	logic [VOICE_W-1:0]  o_voice_q;
	logic                o_gate_q;
	logic                o_last_q;
	logic [STATUS_W-1:0] o_status_q;
	logic [NOTE_W-1:0]   o_note_q;
	logic [VEL_W-1:0]    o_vel_q;

	// input fields
	logic [STATUS_W-1:0] in_status;
	logic [NOTE_W-1:0]   in_note;
	logic [VEL_W-1:0]    in_vel;
	logic [3:0]          in_type;
	logic                s_xfer;

	assign in_status = s_tdata[STATUS_W-1:0];
	assign in_note   = s_tdata[STATUS_W +: NOTE_W];
	assign in_vel    = s_tdata[STATUS_W+NOTE_W +: VEL_W];
	assign in_type   = in_status[7:4];
	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;

	// apb register
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_VOICES_IN_USE);
	assign prdata = (paddr[2] == REG_VOICES_IN_USE) ? APB_DATA_W'(voices_q) : '0;

	// effective voice count, 0 acts as 1, saturates at the slot count
	logic [CFG_W-1:0] n_eff;
	always_comb begin
		if (voices_q == '0) begin
			n_eff = CFG_W'(1);
		end else if (voices_q > SLOTS_C) begin
			n_eff = SLOTS_C;
		end else begin
			n_eff = voices_q;
		end
	end

	// round-robin target and pointer advance
	logic [CFG_W-1:0] ptr_ext;
	logic [CFG_W-1:0] tgt_ext;
	logic [CFG_W-1:0] tgt_inc;
	logic [IDX_W-1:0] tgt_idx;
	logic [IDX_W-1:0] ptr_nxt;
	assign ptr_ext = CFG_W'(next_voice_q);
	assign tgt_ext = (ptr_ext >= n_eff) ? '0 : ptr_ext;
	assign tgt_idx = tgt_ext[IDX_W-1:0];
	assign tgt_inc = tgt_ext + CFG_W'(1);
	assign ptr_nxt = (tgt_inc >= n_eff) ? '0 : tgt_inc[IDX_W-1:0];

	// voice table
	tbl_cmd_t         cmd;
	logic [IDX_W-1:0] tbl_idx;
	logic             match;

	// output register can take a new transfer
	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	// scan halts when a second match must push the pending one out but the output register is busy
	logic scan_stall;
	assign scan_stall = match && pend_vld_q && !out_free;

	assign tbl_idx  = (state_q == ST_ON) ? tgt_idx : scan_q;
	assign cmd.note = msg_note_q;
	assign cmd.set  = (state_q == ST_ON) && out_free;
	assign cmd.clr  = (state_q == ST_SCAN) && match && !scan_stall;

	rrva_voice_table #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (tbl_idx),
		.cmd    (cmd),
		.match  (match)
	);

	// result selection
	logic             emit;
	logic [IDX_W-1:0] emit_idx;
	logic             emit_gate;
	logic             emit_last;
	always_comb begin
		emit      = 1'b0;
		emit_idx  = pend_idx_q;
		emit_gate = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			ST_ON: begin
				emit      = out_free;
				emit_idx  = tgt_idx;
				emit_gate = 1'b1;
				emit_last = 1'b1;
			end
			ST_SCAN: begin
				emit = match && pend_vld_q && out_free;
			end
			ST_FLUSH: begin
				emit      = out_free;
				emit_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			voices_q     <= VOICES_RESET;
			next_voice_q <= '0;
			scan_q       <= '0;
			pend_vld_q   <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				voices_q <= pwdata[CFG_W-1:0];
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						if (in_type == MSG_NOTE_ON && in_vel != '0) begin
							state_q <= ST_ON;
						end else if (in_type == MSG_NOTE_OFF || in_type == MSG_NOTE_ON) begin
							state_q <= ST_SCAN;
							scan_q  <= '0;
						end
					end
				end
				ST_ON: begin
					if (out_free) begin
						next_voice_q <= ptr_nxt;
						state_q      <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (!scan_stall) begin
						if (match) begin
							pend_vld_q <= 1'b1;
						end
						if (scan_q == LAST_SLOT) begin
							state_q <= (match || pend_vld_q) ? ST_FLUSH : ST_IDLE;
						end else begin
							scan_q <= scan_q + IDX_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			msg_status_q <= in_status;
			msg_note_q   <= in_note;
			msg_vel_q    <= in_vel;
		end
		if (state_q == ST_SCAN && match && !scan_stall) begin
			pend_idx_q <= scan_q;
		end
		if (emit) begin
			o_voice_q  <= VOICE_W'(emit_idx);
			o_gate_q   <= emit_gate;
			o_last_q   <= emit_last;
			o_status_q <= msg_status_q;
			o_note_q   <= msg_note_q;
			o_vel_q    <= msg_vel_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {5'b0, o_gate_q, o_vel_q, o_note_q, o_status_q, o_voice_q};

`ifndef SYNTHESIS
	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> pend_vld_q)
		else $error("flush without pending result");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_vld_q)
		else $error("pending result left behind");
	a_gate_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && o_gate_q) |-> o_last_q)
		else $error("note-on result not marked last");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		CFG_W'(next_voice_q) < SLOTS_C)
		else $error("round-robin pointer out of range");
`endif

endmodule
